### rtl/cpu_alu8_with_flags_core_macros.svh
// Assertion macros shared by the ALU core.
`ifndef CPU_ALU8_WITH_FLAGS_CORE_MACROS_SVH
`define CPU_ALU8_WITH_FLAGS_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define CA8_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("ca8 assertion failed (same cycle)");
`define CA8_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("ca8 assertion failed (next cycle)");
`else
`define CA8_ASSERT_NOW(label, clk, rst, pre, post)
`define CA8_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

### rtl/ca8_pkg.sv
// Shared constants and types of the 8-bit ALU core.
`timescale 1ns / 1ps
package ca8_pkg;
   localparam int OP_W             = 3;
   localparam int IDX_FIELD_W      = 3;
   localparam int DATA_W           = 8;
   localparam int NUM_REGS_DEFAULT = 8;

   localparam logic [OP_W-1:0] OP_ADC  = 3'd0;
   localparam logic [OP_W-1:0] OP_SUB  = 3'd1;
   localparam logic [OP_W-1:0] OP_SBC  = 3'd2;
   localparam logic [OP_W-1:0] OP_AND  = 3'd3;
   localparam logic [OP_W-1:0] OP_OR   = 3'd4;
   localparam logic [OP_W-1:0] OP_XOR  = 3'd5;
   localparam logic [OP_W-1:0] OP_CMP  = 3'd6;
   localparam logic [OP_W-1:0] OP_NONE = 3'd7;

   typedef struct packed {
      logic [DATA_W-1:0] result;
      logic              zero;
      logic              subtract;
      logic              half_carry;
      logic              carry;
   } alu_out_type;

   typedef struct packed {
      logic                   en;
      logic [IDX_FIELD_W-1:0] idx;
      logic [DATA_W-1:0]      data;
   } rf_write_type;
endpackage

### rtl/ca8_req_if.sv
// Request and response channel interfaces of the ALU core.
`timescale 1ns / 1ps
interface ca8_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] op;
   logic [2:0] dest_reg;
   logic       use_byte;
   logic [2:0] src_reg;
   logic [7:0] operand_byte;

   modport source (output valid, op, dest_reg, use_byte, src_reg, operand_byte,
                   input ready);
   modport sink (input valid, op, dest_reg, use_byte, src_reg, operand_byte,
                 output ready);
endinterface

interface ca8_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] result_byte;
   logic       zero_flag;
   logic       subtract_flag;
   logic       half_carry_flag;
   logic       carry_flag;

   modport source (output valid, result_byte, zero_flag, subtract_flag,
                   half_carry_flag, carry_flag, input ready);
   modport sink (input valid, result_byte, zero_flag, subtract_flag,
                 half_carry_flag, carry_flag, output ready);
endinterface

### rtl/ca8_regfile.sv
// Register file memory with registered reads, valid bits and write forwarding.
`timescale 1ns / 1ps
module ca8_regfile #(
   parameter int NUM_REGS = ca8_pkg::NUM_REGS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rd_en,
   input  logic [ca8_pkg::IDX_FIELD_W-1:0] rd_idx_a,
   input  logic [ca8_pkg::IDX_FIELD_W-1:0] rd_idx_b,
   input  ca8_pkg::rf_write_type           wr,
   output logic [ca8_pkg::DATA_W-1:0]      rd_data_a,
   output logic [ca8_pkg::DATA_W-1:0]      rd_data_b
);
   import ca8_pkg::*;

   localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int CMP_W = IDX_FIELD_W + 2;

   logic [DATA_W-1:0]   regs_mem [NUM_REGS];
   logic [NUM_REGS-1:0] valid_ff, valid_in;

   logic [IDX_W-1:0]  a_idx, b_idx, w_idx;
   logic              a_ok, b_ok, w_ok, w_live;
   logic [DATA_W-1:0] a_mem_ff, b_mem_ff, fwd_ff;
   logic              a_hit_ff, b_hit_ff, a_zero_ff, b_zero_ff;

   assign a_idx  = IDX_W'(rd_idx_a);
   assign b_idx  = IDX_W'(rd_idx_b);
   assign w_idx  = IDX_W'(wr.idx);
   assign a_ok   = CMP_W'(rd_idx_a) < CMP_W'(NUM_REGS);
   assign b_ok   = CMP_W'(rd_idx_b) < CMP_W'(NUM_REGS);
   assign w_ok   = CMP_W'(wr.idx) < CMP_W'(NUM_REGS);
   assign w_live = wr.en && w_ok;

   always_comb begin
      valid_in = valid_ff;
      if (w_live) begin
         valid_in[w_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (w_live) begin
         regs_mem[w_idx] <= wr.data;
      end
   end

   // The memory returns old data when a read meets a write to the same entry,
   // so the write data is captured and selected in the following cycle.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         a_mem_ff  <= regs_mem[a_idx];
         b_mem_ff  <= regs_mem[b_idx];
         a_hit_ff  <= w_live && (wr.idx == rd_idx_a);
         b_hit_ff  <= w_live && (wr.idx == rd_idx_b);
         a_zero_ff <= !a_ok || !valid_ff[a_idx];
         b_zero_ff <= !b_ok || !valid_ff[b_idx];
         fwd_ff    <= wr.data;
      end
   end

   assign rd_data_a = a_hit_ff ? fwd_ff : (a_zero_ff ? '0 : a_mem_ff);
   assign rd_data_b = b_hit_ff ? fwd_ff : (b_zero_ff ? '0 : b_mem_ff);
endmodule

### rtl/ca8_alu.sv
// Arithmetic and logic unit computing the result byte and the four flags.
`timescale 1ns / 1ps
module ca8_alu (
   input  logic [ca8_pkg::OP_W-1:0]   op,
   input  logic [ca8_pkg::DATA_W-1:0] opnd_a,
   input  logic [ca8_pkg::DATA_W-1:0] opnd_b,
   input  logic                       carry_in,
   output ca8_pkg::alu_out_type       res
);
   import ca8_pkg::*;

   logic [DATA_W:0]     sum_full, diff_full;
   logic [DATA_W/2:0]   sum_low, diff_low;
   logic                sub_carry;

   // Plain subtract and compare ignore the held carry.
   assign sub_carry = (op == OP_SBC) ? carry_in : 1'b0;

   assign sum_full  = {1'b0, opnd_a} + {1'b0, opnd_b} + (DATA_W+1)'(carry_in);
   assign sum_low   = {1'b0, opnd_a[3:0]} + {1'b0, opnd_b[3:0]} + (DATA_W/2+1)'(carry_in);
   assign diff_full = {1'b0, opnd_a} - {1'b0, opnd_b} - (DATA_W+1)'(sub_carry);
   assign diff_low  = {1'b0, opnd_a[3:0]} - {1'b0, opnd_b[3:0]} - (DATA_W/2+1)'(sub_carry);

   always_comb begin
      res = '0;
      case (op)
         OP_ADC: begin
            res.result     = sum_full[DATA_W-1:0];
            res.half_carry = sum_low[DATA_W/2];
            res.carry      = sum_full[DATA_W];
         end
         OP_SUB, OP_SBC, OP_CMP: begin
            res.result     = diff_full[DATA_W-1:0];
            res.subtract   = 1'b1;
            res.half_carry = diff_low[DATA_W/2];
            res.carry      = diff_full[DATA_W];
         end
         OP_AND: begin
            res.result     = opnd_a & opnd_b;
            res.half_carry = 1'b1;
         end
         OP_OR: begin
            res.result = opnd_a | opnd_b;
         end
         OP_XOR: begin
            res.result = opnd_a ^ opnd_b;
         end
         default: begin
            res.result = '0;
         end
      endcase
      res.zero = (res.result == '0);
   end
endmodule

### rtl/cpu_alu8_with_flags_core.sv
// Top level of the 8-bit ALU core with register file and flag register.
//
//   channel    direction  handshake        payload
//   req_chan   in         valid / ready    op, dest_reg, use_byte, src_reg, operand_byte
//   rsp_chan   out        valid / ready    result_byte and Z, N, H, C flags
//
// The register file is read at the accepting edge and the ALU runs in the following
// cycle; write-back and the result register load when the execute stage advances. A
// new item is taken every cycle unless the execute stage is held; a write is forwarded
// to a read of the same register issued at the same edge. Reset clears the flags, and
// all registers through valid bits. The result register stalls the execute stage only
// while the result is not taken; an item with the unused operation code gives no result.
`timescale 1ns / 1ps
`include "cpu_alu8_with_flags_core_macros.svh"
module cpu_alu8_with_flags_core #(
   parameter int NUM_REGS = ca8_pkg::NUM_REGS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   ca8_req_if.sink   req_chan,
   ca8_rsp_if.source rsp_chan
);
   import ca8_pkg::*;

   logic accept, exe_adv, fire;

   logic                   exe_valid_ff, exe_valid_in;
   logic [OP_W-1:0]        exe_op_ff;
   logic [IDX_FIELD_W-1:0] exe_dest_ff;
   logic                   exe_use_byte_ff;
   logic [DATA_W-1:0]      exe_byte_ff;

   logic [DATA_W-1:0] rd_a, rd_b, opnd_b;
   alu_out_type       alu_res;
   rf_write_type      wr;

   logic [3:0]  flags_ff, flags_in;
   logic        out_valid_ff, out_valid_in;
   alu_out_type out_ff;

   assign exe_adv        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !exe_valid_ff || exe_adv;
   assign accept         = req_chan.valid && req_chan.ready;
   assign fire           = exe_valid_ff && exe_adv;

   ca8_regfile #(
      .NUM_REGS(NUM_REGS)
   ) u_regfile (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_idx_a (req_chan.dest_reg),
      .rd_idx_b (req_chan.src_reg),
      .wr       (wr),
      .rd_data_a(rd_a),
      .rd_data_b(rd_b)
   );

   assign opnd_b = exe_use_byte_ff ? exe_byte_ff : rd_b;

   ca8_alu u_alu (
      .op      (exe_op_ff),
      .opnd_a  (rd_a),
      .opnd_b  (opnd_b),
      .carry_in(flags_ff[0]),
      .res     (alu_res)
   );

   assign wr.en   = fire && (exe_op_ff != OP_CMP);
   assign wr.idx  = exe_dest_ff;
   assign wr.data = alu_res.result;

   always_comb begin
      if (accept) begin
         exe_valid_in = (req_chan.op != OP_NONE);
      end else begin
         exe_valid_in = exe_valid_ff && !exe_adv;
      end
      out_valid_in = fire || (out_valid_ff && !rsp_chan.ready);
      flags_in     = fire ? {alu_res.zero, alu_res.subtract, alu_res.half_carry,
                             alu_res.carry} : flags_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exe_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         exe_valid_ff <= exe_valid_in;
         out_valid_ff <= out_valid_in;
         flags_ff     <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         exe_op_ff       <= req_chan.op;
         exe_dest_ff     <= req_chan.dest_reg;
         exe_use_byte_ff <= req_chan.use_byte;
         exe_byte_ff     <= req_chan.operand_byte;
      end
      if (fire) begin
         out_ff <= alu_res;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.result_byte     = out_ff.result;
   assign rsp_chan.zero_flag       = out_ff.zero;
   assign rsp_chan.subtract_flag   = out_ff.subtract;
   assign rsp_chan.half_carry_flag = out_ff.half_carry;
   assign rsp_chan.carry_flag      = out_ff.carry;

   // The held flags always belong to the item waiting at the output.
   `CA8_ASSERT_NOW(a_flags_match_out, clock, reset, out_valid_ff, flags_ff == {out_ff.zero, out_ff.subtract, out_ff.half_carry, out_ff.carry})
   // Every register write is followed by a result on the output.
   `CA8_ASSERT_NEXT(a_write_gives_result, clock, reset, wr.en, out_valid_ff)
   // An item is never taken while the execute stage is held.
   `CA8_ASSERT_NOW(a_no_overrun, clock, reset, accept, !exe_valid_ff || exe_adv)
   // A compare leaves the register file untouched.
   `CA8_ASSERT_NOW(a_cmp_no_write, clock, reset, fire && (exe_op_ff == OP_CMP), !wr.en)
endmodule
